// ===== rtl/wrsi_pkg.sv =====
package wrsi_pkg;

   // field widths fixed by the interface
   localparam int PRICE_FIELD_WIDTH = 32;
   localparam int PERIOD_WIDTH      = 8;
   localparam int RSI_WIDTH         = 23;

   // rsi constants: 100 in Q7.16 and the top bit of the quotient
   localparam logic [RSI_WIDTH-1:0] RSI_HUNDRED = 23'd6553600;
   localparam int                   RSI_BIT_WIDTH = 5;
   localparam logic [RSI_BIT_WIDTH-1:0] RSI_TOP_BIT = 5'd22;

   // moves_seen value that marks the smoothing phase
   localparam logic [PERIOD_WIDTH-1:0] SMOOTHING_PHASE = 8'd255;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET    = 8'd14;

   // quotient bits produced per cycle by the period divider
   localparam int DIV_RADIX_BITS = 4;

   // register file
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SMOOTHING_PERIOD = 1'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_STORE,
      ST_RSI_INIT,
      ST_RSI_ADD,
      ST_RSI_SUB,
      ST_EMIT
   } wrsi_state_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_load;
      logic div_first;
      logic div_step;
      logic avg_store;
      logic sel_loss;
      logic rsi_init;
      logic rsi_add;
      logic rsi_sub;
      logic emit;
      logic emit_valid;
   } wrsi_cmd_type;

   typedef struct packed {
      logic restart;
      logic smoothing;
      logic sum_done;
      logic div_last;
      logic al_zero;
      logic rsi_last;
      logic out_busy;
   } wrsi_status_type;

endpackage

// ===== rtl/wrsi_req_if.sv =====
interface wrsi_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [wrsi_pkg::PRICE_FIELD_WIDTH-1:0]   close_price;
   logic                                      series_start;

   modport source (output valid, output close_price, output series_start, input ready);
   modport sink   (input valid, input close_price, input series_start, output ready);
endinterface

// ===== rtl/wrsi_rsp_if.sv =====
interface wrsi_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wrsi_pkg::RSI_WIDTH-1:0]    rsi_value;
   logic                              rsi_valid;

   modport source (output valid, output rsi_value, output rsi_valid, input ready);
   modport sink   (input valid, input rsi_value, input rsi_valid, output ready);
endinterface

// ===== rtl/wrsi_ctrl.sv =====
module wrsi_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wrsi_pkg::wrsi_status_type status,
   output wrsi_pkg::wrsi_cmd_type    cmd
);
   import wrsi_pkg::*;

   wrsi_state_type state_ff, state_in;
   logic           first_ff, first_in;
   logic           sel_loss_ff, sel_loss_in;
   logic           valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         first_ff    <= 1'b0;
         sel_loss_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         first_ff    <= first_in;
         sel_loss_ff <= sel_loss_in;
         valid_ff    <= valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      first_in       = first_ff;
      sel_loss_in    = sel_loss_ff;
      valid_in       = valid_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.sel_loss   = sel_loss_ff;
      cmd.div_first  = first_ff;
      cmd.emit_valid = valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept  = 1'b1;
               sel_loss_in = 1'b0;
               valid_in    = 1'b0;
               if (status.restart) begin
                  state_in = ST_EMIT;
               end else if (status.smoothing) begin
                  first_in = 1'b0;
                  state_in = ST_MUL;
               end else if (status.sum_done) begin
                  first_in = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.avg_store = 1'b1;
            if (!sel_loss_ff) begin
               sel_loss_in = 1'b1;
               state_in    = first_ff ? ST_LOAD : ST_MUL;
            end else begin
               state_in = ST_RSI_INIT;
            end
         end
         ST_RSI_INIT: begin
            cmd.rsi_init = 1'b1;
            valid_in     = 1'b1;
            state_in     = status.al_zero ? ST_EMIT : ST_RSI_ADD;
         end
         ST_RSI_ADD: begin
            cmd.rsi_add = 1'b1;
            state_in    = ST_RSI_SUB;
         end
         ST_RSI_SUB: begin
            cmd.rsi_sub = 1'b1;
            state_in    = status.rsi_last ? ST_EMIT : ST_RSI_ADD;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/wrsi_dp.sv =====
module wrsi_dp #(
   parameter int PRICE_WIDTH         = 32,
   parameter int EXTRA_FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wrsi_pkg::wrsi_cmd_type                  cmd,
   output wrsi_pkg::wrsi_status_type               status,
   input  logic [wrsi_pkg::PERIOD_WIDTH-1:0]       period,
   input  logic [wrsi_pkg::PRICE_FIELD_WIDTH-1:0]  close_price,
   input  logic                                    series_start,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [wrsi_pkg::RSI_WIDTH-1:0]          rsi_value,
   output logic                                    rsi_valid
);
   import wrsi_pkg::*;

   // averages carry 8 headroom bits so a shortened period cannot overflow
   localparam int AW        = PRICE_WIDTH + EXTRA_FRACTION_BITS;
   localparam int AVG_W     = AW + PERIOD_WIDTH;
   localparam int PROD_W    = AVG_W + PERIOD_WIDTH;
   localparam int NUM_W     = PROD_W + 1;
   localparam int DIV_STEPS = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   localparam int DIV_W     = DIV_STEPS * DIV_RADIX_BITS;
   localparam int DCNT_W    = $clog2(DIV_STEPS);
   localparam int RD_W      = AVG_W + 1;
   localparam int RR_W      = AVG_W + 3;

   // history
   logic [PRICE_WIDTH-1:0]  prev_close_ff, prev_close_in;
   logic                    have_prev_ff, have_prev_in;
   logic [PERIOD_WIDTH-1:0] moves_ff, moves_in;
   logic [AVG_W-1:0]        ag_ff, ag_in;
   logic [AVG_W-1:0]        al_ff, al_in;
   logic [PRICE_WIDTH-1:0]  move_gain_ff, move_gain_in;
   logic [PRICE_WIDTH-1:0]  move_loss_ff, move_loss_in;

   // period divider
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [PERIOD_WIDTH-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;

   // ratio divider
   logic [RD_W-1:0]          den_ff, den_in;
   logic [RR_W-1:0]          racc_ff, racc_in;
   logic [RSI_WIDTH-1:0]     quo_ff, quo_in;
   logic [RSI_BIT_WIDTH-1:0] rbit_ff, rbit_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSI_WIDTH-1:0] out_value_ff, out_value_in;
   logic                 out_flag_ff, out_flag_in;

   logic [PRICE_WIDTH-1:0]  price;
   logic [PRICE_WIDTH-1:0]  gain;
   logic [PRICE_WIDTH-1:0]  loss;
   logic [PERIOD_WIDTH-1:0] p_eff;
   logic [PERIOD_WIDTH-1:0] p_m1;
   logic [AVG_W-1:0]        avg_sel;
   logic [PRICE_WIDTH-1:0]  move_sel;
   logic [DIV_W-1:0]        step_div;
   logic [PERIOD_WIDTH-1:0] step_rem;
   logic [PERIOD_WIDTH:0]   trial;
   logic [RR_W-1:0]         den1;
   logic [RR_W-1:0]         den2;

   assign price    = PRICE_WIDTH'(close_price);
   assign gain     = (price > prev_close_ff) ? price - prev_close_ff : '0;
   assign loss     = (price > prev_close_ff) ? '0 : prev_close_ff - price;
   assign p_eff    = (period == '0) ? PERIOD_WIDTH'(1) : period;
   assign p_m1     = p_eff - PERIOD_WIDTH'(1);
   assign avg_sel  = cmd.sel_loss ? al_ff : ag_ff;
   assign move_sel = cmd.sel_loss ? move_loss_ff : move_gain_ff;
   assign den1     = RR_W'(den_ff);
   assign den2     = RR_W'({den_ff, 1'b0});

   assign status.restart   = series_start || !have_prev_ff;
   assign status.smoothing = (moves_ff == SMOOTHING_PHASE);
   assign status.sum_done  = ({1'b0, moves_ff} + (PERIOD_WIDTH+1)'(1)) >= {1'b0, p_eff};
   assign status.div_last  = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));
   assign status.al_zero   = (al_ff == '0);
   assign status.rsi_last  = (rbit_ff == '0);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   // four restoring steps of the long division by the period
   always_comb begin
      step_div = div_ff;
      step_rem = rem_ff;
      trial    = '0;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial    = {step_rem, step_div[DIV_W-1]};
         step_div = {step_div[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, p_eff}) begin
            trial       = trial - {1'b0, p_eff};
            step_div[0] = 1'b1;
         end
         step_rem = trial[PERIOD_WIDTH-1:0];
      end
   end

   always_comb begin
      prev_close_in = prev_close_ff;
      have_prev_in  = have_prev_ff;
      moves_in      = moves_ff;
      ag_in         = ag_ff;
      al_in         = al_ff;
      move_gain_in  = move_gain_ff;
      move_loss_in  = move_loss_ff;
      prod_in       = prod_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      den_in        = den_ff;
      racc_in       = racc_ff;
      quo_in        = quo_ff;
      rbit_in       = rbit_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_value_in  = out_value_ff;
      out_flag_in   = out_flag_ff;

      if (cmd.accept) begin
         prev_close_in = price;
         have_prev_in  = 1'b1;
         if (status.restart) begin
            moves_in = '0;
            ag_in    = '0;
            al_in    = '0;
         end else begin
            move_gain_in = gain;
            move_loss_in = loss;
            if (!status.smoothing) begin
               ag_in    = ag_ff + AVG_W'(gain);
               al_in    = al_ff + AVG_W'(loss);
               moves_in = status.sum_done ? SMOOTHING_PHASE : moves_ff + PERIOD_WIDTH'(1);
            end
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(avg_sel) * PROD_W'(p_m1);
      end

      if (cmd.div_load) begin
         if (cmd.div_first) begin
            div_in = DIV_W'(avg_sel) << EXTRA_FRACTION_BITS;
         end else begin
            div_in = DIV_W'(prod_ff) + (DIV_W'(move_sel) << EXTRA_FRACTION_BITS);
         end
         rem_in  = '0;
         dcnt_in = '0;
      end

      if (cmd.div_step) begin
         div_in  = step_div;
         rem_in  = step_rem;
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end

      if (cmd.avg_store) begin
         if (cmd.sel_loss) begin
            al_in = AVG_W'(div_ff);
         end else begin
            ag_in = AVG_W'(div_ff);
         end
      end

      if (cmd.rsi_init) begin
         den_in  = RD_W'(ag_ff) + RD_W'(al_ff);
         racc_in = '0;
         quo_in  = status.al_zero ? RSI_HUNDRED : '0;
         rbit_in = RSI_TOP_BIT;
      end

      if (cmd.rsi_add) begin
         racc_in = (racc_ff << 1) + (RSI_HUNDRED[rbit_ff] ? RR_W'(ag_ff) : '0);
         quo_in  = quo_ff << 1;
      end

      // remainder is below three times the divisor here
      if (cmd.rsi_sub) begin
         if (racc_ff >= den2) begin
            racc_in = racc_ff - den2;
            quo_in  = quo_ff + RSI_WIDTH'(2);
         end else if (racc_ff >= den1) begin
            racc_in = racc_ff - den1;
            quo_in  = quo_ff + RSI_WIDTH'(1);
         end
         rbit_in = rbit_ff - RSI_BIT_WIDTH'(1);
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_value_in = cmd.emit_valid ? quo_ff : '0;
         out_flag_in  = cmd.emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_close_ff <= '0;
         have_prev_ff  <= 1'b0;
         moves_ff      <= '0;
         ag_ff         <= '0;
         al_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_close_ff <= prev_close_in;
         have_prev_ff  <= have_prev_in;
         moves_ff      <= moves_in;
         ag_ff         <= ag_in;
         al_ff         <= al_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      move_gain_ff <= move_gain_in;
      move_loss_ff <= move_loss_in;
      prod_ff      <= prod_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      den_ff       <= den_in;
      racc_ff      <= racc_in;
      quo_ff       <= quo_in;
      rbit_ff      <= rbit_in;
      out_value_ff <= out_value_in;
      out_flag_ff  <= out_flag_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsi_value = out_value_ff;
   assign rsi_valid = out_flag_ff;

endmodule

// ===== rtl/wilder_rsi_stream_top.sv =====
// streaming relative strength index with wilder smoothing: each item on req_ch carries a
// closing price (unsigned Q16.16) and a series start flag, and gives exactly one item on
// rsp_ch holding the rsi in unsigned Q7.16 and a valid flag; the first price of a series
// is only stored, the next smoothing_period moves are summed, and from then on the gain
// and loss averages are smoothed; one item is worked on at a time: an item that gives no
// valid rsi goes straight to the output, a valid one runs the 4-bit per cycle divider by
// the period, S = ceil((PRICE_WIDTH+EXTRA_FRACTION_BITS+17)/4) passes, once for the gain
// and once for the loss, and then the bit-serial ratio divider (an add and a subtract
// step per result bit, skipped when the average loss is zero); a finished item sits in
// the output register while the next one is taken in; the period register sits at byte
// address 0 and resets to 14
module wilder_rsi_stream_top #(
   parameter int PRICE_WIDTH         = 32,
   parameter int EXTRA_FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   wrsi_req_if.sink                              req_ch,
   wrsi_rsp_if.source                            rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wrsi_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [wrsi_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [wrsi_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import wrsi_pkg::*;

   wrsi_cmd_type              cmd;
   wrsi_status_type           status;
   logic [PERIOD_WIDTH-1:0]   period_ff, period_in;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                      csr_write;

   // register file: word index from the address, write on the access phase
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      period_in  = period_ff;
      csr_prdata = '0;
      unique case (csr_index)
         REG_SMOOTHING_PERIOD: begin
            csr_prdata = CSR_DATA_WIDTH'(period_ff);
            if (csr_write) begin
               period_in = csr_pwdata[PERIOD_WIDTH-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // sequencer: takes an item in idle, then steps the dividers
   wrsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // history, averages, both dividers and the output register
   wrsi_dp #(
      .PRICE_WIDTH         (PRICE_WIDTH),
      .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .period       (period_ff),
      .close_price  (req_ch.close_price),
      .series_start (req_ch.series_start),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsi_value    (rsp_ch.rsi_value),
      .rsi_valid    (rsp_ch.rsi_valid)
   );

endmodule
